// ----- hw/rtl/depth_map_triangulator_top_macros.svh -----
// ----------------------------------------------------------------------------
// depth_map_triangulator_top_macros
// assertion macros shared by the triangulator rtl, clocked on i_clk and
// disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef DEPTH_MAP_TRIANGULATOR_TOP_MACROS_SVH
`define DEPTH_MAP_TRIANGULATOR_TOP_MACROS_SVH

// condition implies consequence in the same cycle
`define DMT_ASSERT_NOW(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("dmt assertion failed");

// condition implies consequence in the next cycle
`define DMT_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("dmt assertion failed");

`endif

// ----- hw/rtl/dmt_pkg.sv -----
// ----------------------------------------------------------------------------
// dmt_pkg
// types, constants and corner tables of the depth map triangulator
// ----------------------------------------------------------------------------
package dmt_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int DEPTH_BITS_DEF = 16;

    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int DIM_CFG_W   = 11;
    localparam int INV_W       = 24;
    localparam int LIMIT_W     = 16;
    localparam int SAMPLE_W    = 16;
    localparam int XY_W        = 24;
    localparam int TEX_W       = 17;
    localparam int FOCAL_SPLIT = 24;
    localparam int XY_SHIFT    = 25;
    localparam int TEX_SHIFT   = 8;
    localparam int RATIO_SHIFT = 16;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [2:0] REG_IMAGE_WIDTH       = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT      = 3'd1;
    localparam logic [2:0] REG_INVERSE_FOCAL     = 3'd2;
    localparam logic [2:0] REG_INV_WIDTH_SPAN    = 3'd3;
    localparam logic [2:0] REG_INV_HEIGHT_SPAN   = 3'd4;
    localparam logic [2:0] REG_DEPTH_RATIO_LIMIT = 3'd5;

    localparam logic [DIM_CFG_W-1:0] IMAGE_WIDTH_RST   = 11'd1024;
    localparam logic [DIM_CFG_W-1:0] IMAGE_HEIGHT_RST  = 11'd1024;
    localparam logic [INV_W-1:0]     INV_FOCAL_RST     = 24'd16384;
    localparam logic [INV_W-1:0]     INV_SPAN_RST      = 24'd16400;
    localparam logic [LIMIT_W-1:0]   RATIO_LIMIT_RST   = 16'd3277;

    localparam logic [TEX_W-1:0] TEX_ONE       = 17'h10000;
    localparam logic [XY_W-1:0]  XY_POS_MAX    = 24'h7FFFFF;
    localparam logic [XY_W-1:0]  XY_NEG_MIN    = 24'h800000;
    localparam logic [PROD_W-1:0] XY_POS_LIM   = 64'd8388607;
    localparam logic [PROD_W-1:0] XY_NEG_LIM   = 64'd8388608;

    typedef logic [1:0] t_corner;
    typedef logic [1:0] t_tri_sel;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_op;

    // corner order of the four candidate triangles
    function automatic t_corner tri_corner(input t_tri_sel sel, input logic [1:0] pos);
        t_corner c;
        c = 2'd0;
        case (sel)
            2'd0: begin
                case (pos)
                    2'd0:    c = 2'd3;
                    2'd1:    c = 2'd1;
                    default: c = 2'd2;
                endcase
            end
            2'd1: begin
                case (pos)
                    2'd0:    c = 2'd0;
                    2'd1:    c = 2'd2;
                    default: c = 2'd3;
                endcase
            end
            2'd2: begin
                case (pos)
                    2'd0:    c = 2'd3;
                    2'd1:    c = 2'd1;
                    default: c = 2'd0;
                endcase
            end
            default: begin
                case (pos)
                    2'd0:    c = 2'd0;
                    2'd1:    c = 2'd2;
                    default: c = 2'd1;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/dmt_mul.sv -----
// ----------------------------------------------------------------------------
// dmt_mul
// shared registered 32x32 unsigned multiplier, one product per cycle
// ----------------------------------------------------------------------------
module dmt_mul (
    input  logic                        i_clk,
    input  dmt_pkg::t_mul_op            i_op,
    output logic [dmt_pkg::PROD_W-1:0]  o_prod
);
    import dmt_pkg::*;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_op.a) * PROD_W'(i_op.b);
    end

    assign o_prod = r_prod;

endmodule

// ----- hw/rtl/depth_map_triangulator_top.sv -----
// ----------------------------------------------------------------------------
// depth_map_triangulator_top
// streaming depth map triangulator: line store, quad split, vertex projection
// ----------------------------------------------------------------------------
// usage
// depth samples enter in raster order on i_depth_sample under i_in_valid /
// o_in_stall; each transaction may complete a 2x2 quad, which yields zero,
// three or six vertex transactions on the output channel (o_out_valid /
// i_out_stall), the final one of the quad flagged by o_last_vertex.
// the block takes one sample at a time and stalls its input until all
// vertices of that sample have been taken. all multiplies run one after
// another on a single registered 32x32 multiplier:
//   sample without triangles: accept, then load
//   each triangle corner pair check: limit multiply, then compare (up to 6 pairs)
//   each vertex: the steps xz, xlo, xhi, yz, ylo, yhi, u, v and done, then emit
// a stall holds the vertex in the output registers.
// the apb port sets geometry, reciprocals and the ratio limit; write it
// only while the block is idle. reset (i_rst_n low, synchronous) restores
// the register defaults and starts a new image at row 0, column 0; the
// line store needs no clearing.
// ----------------------------------------------------------------------------
module depth_map_triangulator_top #(
    parameter int MAX_WIDTH  = dmt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dmt_pkg::MAX_HEIGHT_DEF,
    parameter int DEPTH_BITS = dmt_pkg::DEPTH_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [dmt_pkg::SAMPLE_W-1:0]       i_depth_sample,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [dmt_pkg::XY_W-1:0]    o_vertex_x,
    output logic signed [dmt_pkg::XY_W-1:0]    o_vertex_y,
    output logic [dmt_pkg::SAMPLE_W-1:0]       o_vertex_z,
    output logic [dmt_pkg::TEX_W-1:0]          o_tex_u,
    output logic [dmt_pkg::TEX_W-1:0]          o_tex_v,
    output logic                               o_last_vertex,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dmt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [dmt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dmt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import dmt_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int DW = (WW > HW) ? WW : HW;
    localparam int M1_W = DEPTH_BITS + DW + 1;
    localparam int LO_W = FOCAL_SPLIT + INV_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_VERTEX = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    localparam logic [3:0] VS_XZ   = 4'd0;
    localparam logic [3:0] VS_XLO  = 4'd1;
    localparam logic [3:0] VS_XHI  = 4'd2;
    localparam logic [3:0] VS_YZ   = 4'd3;
    localparam logic [3:0] VS_YLO  = 4'd4;
    localparam logic [3:0] VS_YHI  = 4'd5;
    localparam logic [3:0] VS_U    = 4'd6;
    localparam logic [3:0] VS_V    = 4'd7;
    localparam logic [3:0] VS_DONE = 4'd8;

    // configuration
    logic [DIM_CFG_W-1:0] r_img_w, r_img_h;
    logic [INV_W-1:0]     r_inv_focal, r_inv_wspan, r_inv_hspan;
    logic [LIMIT_W-1:0]   r_limit;

    // control
    logic [2:0]      r_state;
    logic [3:0]      r_step;
    logic [1:0]      r_pair;
    logic [1:0]      r_j;
    logic            r_t;
    logic [1:0]      r_keep;
    t_tri_sel        r_tri0, r_tri1;
    logic [CW-1:0]   r_col, r_qcol;
    logic [RW-1:0]   r_row, r_qrow;
    logic [DEPTH_BITS-1:0] r_left, r_ul;

    // payload
    logic [DEPTH_BITS-1:0] r_line_store [MAX_WIDTH];
    logic [DEPTH_BITS-1:0] r_above;
    logic [DEPTH_BITS-1:0] r_dul, r_dup, r_dlf, r_dcur;
    logic [DEPTH_BITS-1:0] r_diff;
    logic [M1_W-1:0]       r_m1;
    logic [LO_W-1:0]       r_acc;
    logic [XY_W-1:0]       r_vx, r_vy;
    logic [TEX_W-1:0]      r_u, r_v;

    logic                  in_acc, out_acc, cfg_wr;
    logic [DEPTH_BITS-1:0] sample;
    logic [WW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;
    logic [CW-1:0]         n_col;
    logic [RW-1:0]         n_row;
    t_mul_op               mul_op;
    logic [PROD_W-1:0]     prod;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign in_acc = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;
    assign sample = DEPTH_BITS'(i_depth_sample);

    assign w_eff = (r_img_w < DIM_CFG_W'(2)) ? WW'(2)
                 : (32'(r_img_w) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_img_w);
    assign h_eff = (r_img_h < DIM_CFG_W'(2)) ? HW'(2)
                 : (32'(r_img_h) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_img_h);

    // raster position after this sample
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (32'(r_col) >= 32'(w_eff) - 32'd1) begin
            n_col = '0;
            if (32'(r_row) >= 32'(h_eff) - 32'd1) begin
                n_row = '0;
            end else begin
                n_row = r_row + RW'(1);
            end
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    // ---------------- quad classification ----------------
    logic [3:0]            nz;
    logic [2:0]            n_valid;
    logic [DEPTH_BITS-1:0] diag03, diag12;
    logic                  quad_ok;
    t_tri_sel              one_tri;

    assign nz = {r_dcur != '0, r_dlf != '0, r_above != '0, r_dul != '0};
    assign n_valid = 3'($countones(nz));
    assign diag03 = (r_dul > r_dcur) ? r_dul - r_dcur : r_dcur - r_dul;
    assign diag12 = (r_above > r_dlf) ? r_above - r_dlf : r_dlf - r_above;
    assign quad_ok = (r_qcol != '0) && (r_qrow != '0) &&
                     (n_valid == 3'd3 || n_valid == 3'd4);

    always_comb begin
        if (!nz[0]) begin
            one_tri = 2'd0;
        end else if (!nz[1]) begin
            one_tri = 2'd1;
        end else if (!nz[2]) begin
            one_tri = 2'd2;
        end else begin
            one_tri = 2'd3;
        end
    end

    // ---------------- corner selection ----------------
    t_tri_sel              cur_tri;
    t_corner               pa_k, pb_k, vk;
    logic [DEPTH_BITS-1:0] pa_d, pb_d, vz, pair_max, pair_diff;
    logic [1:0]            pb_pos;

    assign cur_tri = r_t ? r_tri1 : r_tri0;
    assign pb_pos = (r_pair == 2'd2) ? 2'd0 : r_pair + 2'd1;
    assign pa_k = tri_corner(cur_tri, r_pair);
    assign pb_k = tri_corner(cur_tri, pb_pos);
    assign vk = tri_corner(cur_tri, r_j);

    always_comb begin
        case (pa_k)
            2'd0:    pa_d = r_dul;
            2'd1:    pa_d = r_dup;
            2'd2:    pa_d = r_dlf;
            default: pa_d = r_dcur;
        endcase
        case (pb_k)
            2'd0:    pb_d = r_dul;
            2'd1:    pb_d = r_dup;
            2'd2:    pb_d = r_dlf;
            default: pb_d = r_dcur;
        endcase
        case (vk)
            2'd0:    vz = r_dul;
            2'd1:    vz = r_dup;
            2'd2:    vz = r_dlf;
            default: vz = r_dcur;
        endcase
    end

    assign pair_max = (pa_d > pb_d) ? pa_d : pb_d;
    assign pair_diff = (pa_d > pb_d) ? pa_d - pb_d : pb_d - pa_d;

    // ---------------- vertex geometry ----------------
    logic [DW-1:0]          vx_pix, vy_pix;
    logic signed [DW+1:0]   num_x, num_y;
    logic                   neg_x, neg_y;
    logic [DW:0]            mag_x, mag_y;

    assign vx_pix = DW'(r_qcol) - DW'(1) + DW'(vk[0]);
    assign vy_pix = DW'(r_qrow) - DW'(1) + DW'(vk[1]);
    assign num_x = $signed({1'b0, vx_pix, 1'b0}) - $signed((DW+2)'(w_eff));
    assign num_y = $signed({1'b0, vy_pix, 1'b0}) - $signed((DW+2)'(h_eff));
    assign neg_x = num_x[DW+1];
    assign neg_y = num_y[DW+1];
    assign mag_x = (DW+1)'(neg_x ? -num_x : num_x);
    assign mag_y = (DW+1)'(neg_y ? -num_y : num_y);

    function automatic logic [XY_W-1:0] sat_xy(input logic [PROD_W-1:0] sum,
                                               input logic neg);
        logic [PROD_W-1:0] q;
        logic [XY_W-1:0]   res;
        q = sum >> XY_SHIFT;
        if (neg) begin
            res = (q > XY_NEG_LIM) ? XY_NEG_MIN : XY_W'(-q);
        end else begin
            res = (q > XY_POS_LIM) ? XY_POS_MAX : XY_W'(q);
        end
        return res;
    endfunction

    function automatic logic [TEX_W-1:0] tex_frac(input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] t;
        t = (p + PROD_W'(128)) >> TEX_SHIFT;
        return (t > PROD_W'(TEX_ONE)) ? TEX_ONE : TEX_W'(t);
    endfunction

    logic [PROD_W-1:0] xy_sum;
    assign xy_sum = PROD_W'(r_acc) + (prod << FOCAL_SPLIT) + (PROD_W'(1) << (XY_SHIFT - 1));

    // ---------------- shared multiplier ----------------
    always_comb begin
        mul_op = '0;
        if (r_state == ST_CHECK && r_step == VS_XZ) begin
            mul_op.a = MUL_W'(r_limit);
            mul_op.b = MUL_W'(pair_max);
        end else if (r_state == ST_VERTEX) begin
            case (r_step)
                VS_XZ: begin
                    mul_op.a = MUL_W'(vz);
                    mul_op.b = MUL_W'(mag_x);
                end
                VS_XLO, VS_YLO: begin
                    mul_op.a = MUL_W'(prod[FOCAL_SPLIT-1:0]);
                    mul_op.b = MUL_W'(r_inv_focal);
                end
                VS_XHI, VS_YHI: begin
                    mul_op.a = MUL_W'(r_m1 >> FOCAL_SPLIT);
                    mul_op.b = MUL_W'(r_inv_focal);
                end
                VS_YZ: begin
                    mul_op.a = MUL_W'(vz);
                    mul_op.b = MUL_W'(mag_y);
                end
                VS_U: begin
                    mul_op.a = MUL_W'(vx_pix);
                    mul_op.b = MUL_W'(r_inv_wspan);
                end
                VS_V: begin
                    mul_op.a = MUL_W'(vy_pix);
                    mul_op.b = MUL_W'(r_inv_hspan);
                end
                default: mul_op = '0;
            endcase
        end
    end

    dmt_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (prod)
    );

    // ---------------- triangle check outcome ----------------
    logic       pair_fail, tri_done;
    logic [1:0] keep_now;

    assign pair_fail = !((PROD_W'(r_diff) << RATIO_SHIFT) < prod);
    assign tri_done = pair_fail || (r_pair == 2'd2);
    always_comb begin
        keep_now = r_keep;
        if (pair_fail) begin
            keep_now[r_t] = 1'b0;
        end
    end

    // ---------------- configuration port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w     <= IMAGE_WIDTH_RST;
            r_img_h     <= IMAGE_HEIGHT_RST;
            r_inv_focal <= INV_FOCAL_RST;
            r_inv_wspan <= INV_SPAN_RST;
            r_inv_hspan <= INV_SPAN_RST;
            r_limit     <= RATIO_LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_IMAGE_WIDTH:       r_img_w     <= pwdata[DIM_CFG_W-1:0];
                REG_IMAGE_HEIGHT:      r_img_h     <= pwdata[DIM_CFG_W-1:0];
                REG_INVERSE_FOCAL:     r_inv_focal <= pwdata[INV_W-1:0];
                REG_INV_WIDTH_SPAN:    r_inv_wspan <= pwdata[INV_W-1:0];
                REG_INV_HEIGHT_SPAN:   r_inv_hspan <= pwdata[INV_W-1:0];
                REG_DEPTH_RATIO_LIMIT: r_limit     <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_IMAGE_WIDTH:       prdata = APB_DATA_W'(r_img_w);
            REG_IMAGE_HEIGHT:      prdata = APB_DATA_W'(r_img_h);
            REG_INVERSE_FOCAL:     prdata = APB_DATA_W'(r_inv_focal);
            REG_INV_WIDTH_SPAN:    prdata = APB_DATA_W'(r_inv_wspan);
            REG_INV_HEIGHT_SPAN:   prdata = APB_DATA_W'(r_inv_hspan);
            REG_DEPTH_RATIO_LIMIT: prdata = APB_DATA_W'(r_limit);
            default:               prdata = '0;
        endcase
    end

    // ---------------- line store ----------------
    // read returns the previous row before this sample overwrites it
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_above <= r_line_store[r_col];
            r_line_store[r_col] <= sample;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= VS_XZ;
            r_pair  <= '0;
            r_j     <= '0;
            r_t     <= 1'b0;
            r_keep  <= '0;
            r_tri0  <= '0;
            r_tri1  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_qcol  <= '0;
            r_qrow  <= '0;
            r_left  <= '0;
            r_ul    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_qcol  <= r_col;
                        r_qrow  <= r_row;
                        r_col   <= n_col;
                        r_row   <= n_row;
                        r_left  <= sample;
                        r_state <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    r_ul   <= r_above;
                    r_t    <= 1'b0;
                    r_pair <= '0;
                    r_step <= VS_XZ;
                    if (n_valid == 3'd4) begin
                        r_keep <= 2'b11;
                        r_tri0 <= (diag03 > diag12) ? 2'd0 : 2'd1;
                        r_tri1 <= (diag03 > diag12) ? 2'd3 : 2'd2;
                    end else begin
                        r_keep <= 2'b01;
                        r_tri0 <= one_tri;
                        r_tri1 <= one_tri;
                    end
                    r_state <= quad_ok ? ST_CHECK : ST_IDLE;
                end
                ST_CHECK: begin
                    if (r_step == VS_XZ) begin
                        r_step <= VS_XLO;
                    end else begin
                        r_step <= VS_XZ;
                        if (tri_done) begin
                            r_keep <= keep_now;
                            if (!r_t && r_keep[1]) begin
                                r_t    <= 1'b1;
                                r_pair <= '0;
                            end else if (keep_now == 2'b00) begin
                                r_state <= ST_IDLE;
                            end else begin
                                r_t     <= !keep_now[0];
                                r_j     <= '0;
                                r_state <= ST_VERTEX;
                            end
                        end else begin
                            r_pair <= r_pair + 2'd1;
                        end
                    end
                end
                ST_VERTEX: begin
                    if (r_step == VS_DONE) begin
                        r_state <= ST_EMIT;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_EMIT: begin
                    if (out_acc) begin
                        r_step <= VS_XZ;
                        if (r_j == 2'd2) begin
                            if (!r_t && r_keep[1]) begin
                                r_t     <= 1'b1;
                                r_j     <= '0;
                                r_state <= ST_VERTEX;
                            end else begin
                                r_state <= ST_IDLE;
                            end
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= ST_VERTEX;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---------------- datapath captures ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dul  <= r_ul;
            r_dlf  <= r_left;
            r_dcur <= sample;
        end
        if (r_state == ST_LOAD) begin
            r_dup <= r_above;
        end
        if (r_state == ST_CHECK && r_step == VS_XZ) begin
            r_diff <= pair_diff;
        end
        if (r_state == ST_VERTEX) begin
            case (r_step)
                VS_XLO, VS_YLO: r_m1  <= M1_W'(prod);
                VS_XHI, VS_YHI: r_acc <= LO_W'(prod);
                VS_YZ:          r_vx  <= sat_xy(xy_sum, neg_x);
                VS_U:           r_vy  <= sat_xy(xy_sum, neg_y);
                VS_V:           r_u   <= tex_frac(prod);
                VS_DONE:        r_v   <= TEX_ONE - tex_frac(prod);
                default: ;
            endcase
        end
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = (r_state == ST_EMIT);
    assign o_vertex_x    = $signed(r_vx);
    assign o_vertex_y    = $signed(r_vy);
    assign o_vertex_z    = SAMPLE_W'(vz);
    assign o_tex_u       = r_u;
    assign o_tex_v       = r_v;
    assign o_last_vertex = (r_j == 2'd2) && (r_t || !r_keep[1]);

    // ---------------- assertions ----------------
    `include "depth_map_triangulator_top_macros.svh"

    `DMT_ASSERT_NEXT(a_accept_loads, in_acc, r_state == ST_LOAD)
    `DMT_ASSERT_NOW(a_emit_kept, r_state == ST_EMIT, r_keep[r_t])
    `DMT_ASSERT_NEXT(a_last_idles, out_acc && o_last_vertex, r_state == ST_IDLE)
    `DMT_ASSERT_NOW(a_col_bound, r_state == ST_IDLE, 32'(r_col) < MAX_WIDTH)

endmodule
